### rtl/udp_flow_table_demux_core_macros.svh
// Assertion macros for the UDP flow table.
`ifndef UDP_FLOW_TABLE_DEMUX_CORE_MACROS_SVH
`define UDP_FLOW_TABLE_DEMUX_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define UFT_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("udp flow table: implication check failed");
`define UFT_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("udp flow table: next-cycle check failed");
`else
`define UFT_ASSERT_IMP(name, ante, cons)
`define UFT_ASSERT_NXT(name, ante, cons)
`endif

`endif

### rtl/udpft_pkg.sv
`timescale 1ns / 1ps

package udpft_pkg;

	localparam int DEF_TABLE_DEPTH = 16;

	localparam logic [15:0] UDP_HDR_BYTES = 16'd8;
	localparam logic [15:0] PORT_RESET    = 16'd1024;

	localparam logic [1:0] REQ_CONNECT    = 2'd0;
	localparam logic [1:0] REQ_DISCONNECT = 2'd1;
	localparam logic [1:0] REQ_RECEIVE    = 2'd2;
	localparam logic [1:0] REQ_SEND       = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_MATCH = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_SHORT    = 2'd3;

	localparam logic [0:0] REG_OWN_ADDRESS = 1'b0;
	localparam logic [0:0] REG_FIRST_PORT  = 1'b1;

	typedef struct packed {
		logic [31:0] local_ip;
		logic [31:0] remote_ip;
		logic [15:0] local_port;
		logic [15:0] remote_port;
	} flow_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] peer_ip;
		logic [15:0] peer_port;
		logic [31:0] dest_ip;
		logic [15:0] handle_port;
		logic [15:0] byte_count;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] local_port;
		logic [15:0] remote_port;
		logic [31:0] remote_ip;
		logic [15:0] length;
	} resp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CONN,
		S_SHORT,
		S_SCAN,
		S_MOVE_RD,
		S_MOVE_WR
	} state_t;

	function automatic logic [15:0] swap16(input logic [15:0] v);
		return {v[7:0], v[15:8]};
	endfunction

endpackage

### rtl/udpft_table.sv
`timescale 1ns / 1ps

module udpft_table
	import udpft_pkg::*;
#(
	parameter int DEPTH = DEF_TABLE_DEPTH,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  flow_t         wr_data,
	input  logic [AW-1:0] rd_addr,
	output flow_t         rd_data
);

	flow_t mem [DEPTH];
	flow_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

### rtl/udp_flow_table_demux_core.sv
`timescale 1ns / 1ps
// UDP flow table: keeps up to TABLE_DEPTH four-tuples (local/remote IP and port,
// ports in network order) and serves connect, disconnect, receive and send items.
// Channels: an item is taken at a rising edge with start high and busy low; busy
// stays high until the result is out. Each item gives exactly one result, shown
// for one cycle with done high; the receiver cannot stall, so nothing waits.
// Configuration: cfg_we/cfg_index/cfg_data write own_address (0) or first_port
// (1); writing first_port also reloads the port counter. Write only while idle.
// Connect and short receive load their result in S_CONN or S_SHORT.
// Receive, send and disconnect walk the table one entry per cycle through the
// single read port and one shared comparator until a hit or the end of the
// entries; a hit disconnect then copies the last entry into the freed slot
// (S_MOVE_RD, then S_MOVE_WR). Busy drops in the done cycle, so the next item
// can be taken at the edge that ends it.
// Reset: entry count clears, first_port and the counter go to 1024, own_address
// to 0. Table contents need no clearing since only entries below the count are read.
`include "udp_flow_table_demux_core_macros.svh"

module udp_flow_table_demux_core
	import udpft_pkg::*;
#(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [31:0] peer_ip,
	input  logic [15:0] peer_port,
	input  logic [31:0] dest_ip,
	input  logic [15:0] handle_port,
	input  logic [15:0] byte_count,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output logic        done,
	output logic [1:0]  status,
	output logic [15:0] local_port_out,
	output logic [15:0] remote_port_out,
	output logic [31:0] remote_ip_out,
	output logic [15:0] length_out
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	state_t         state_q, state_d;
	req_t           req_q;
	logic [CW-1:0]  count_q;
	logic [CW-1:0]  scan_idx_q;
	logic [AW-1:0]  cmp_idx_q;
	logic           cmp_vld_q;
	logic [AW-1:0]  slot_q;
	logic [31:0]    own_address_q;
	logic [15:0]    first_port_q;
	logic [15:0]    next_port_q;
	resp_t          resp_q, resp_d;
	logic           done_q;

	logic           accept;
	logic           resp_load;
	logic           mem_we;
	logic [AW-1:0]  mem_waddr;
	flow_t          mem_wdata;
	logic [AW-1:0]  mem_raddr;
	flow_t          rd_flow;
	logic           hit;
	logic           count_inc, count_dec;
	logic [CW-1:0]  last_idx;

	assign accept   = start && (state_q == S_IDLE);
	assign busy     = (state_q != S_IDLE);
	assign last_idx = count_q - 1'b1;

	udpft_table #(
		.DEPTH (TABLE_DEPTH),
		.AW    (AW)
	) u_table (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (mem_waddr),
		.wr_data (mem_wdata),
		.rd_addr (mem_raddr),
		.rd_data (rd_flow)
	);

	// shared comparator: full four-tuple on receive, local port otherwise
	always_comb begin
		hit = (rd_flow.local_port == req_q.handle_port);
		if (req_q.req_type == REQ_RECEIVE) begin
			hit = hit && (rd_flow.remote_port == req_q.peer_port) &&
				(rd_flow.local_ip == req_q.dest_ip) &&
				(rd_flow.remote_ip == req_q.peer_ip);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		resp_load = 1'b0;
		resp_d    = '0;
		mem_we    = 1'b0;
		mem_waddr = count_q[AW-1:0];
		mem_wdata = rd_flow;
		mem_raddr = scan_idx_q[AW-1:0];
		count_inc = 1'b0;
		count_dec = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (req_type == REQ_CONNECT) begin
						state_d = S_CONN;
					end else if (req_type == REQ_RECEIVE && byte_count < UDP_HDR_BYTES) begin
						state_d = S_SHORT;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_CONN: begin
				resp_load = 1'b1;
				state_d   = S_IDLE;
				if (count_q >= DEPTH_C) begin
					resp_d.status = ST_FULL;
				end else begin
					mem_we               = 1'b1;
					mem_wdata.local_ip    = own_address_q;
					mem_wdata.remote_ip   = req_q.peer_ip;
					mem_wdata.local_port  = swap16(next_port_q);
					mem_wdata.remote_port = swap16(req_q.peer_port);
					count_inc            = 1'b1;
					resp_d.status        = ST_OK;
					resp_d.local_port    = swap16(next_port_q);
				end
			end
			S_SHORT: begin
				resp_load     = 1'b1;
				resp_d.status = ST_SHORT;
				state_d       = S_IDLE;
			end
			S_SCAN: begin
				if (cmp_vld_q && hit) begin
					unique case (req_q.req_type)
						REQ_DISCONNECT: begin
							state_d = S_MOVE_RD;
						end
						REQ_RECEIVE: begin
							resp_load         = 1'b1;
							resp_d.status     = ST_OK;
							resp_d.local_port = rd_flow.local_port;
							resp_d.length     = req_q.byte_count - UDP_HDR_BYTES;
							state_d           = S_IDLE;
						end
						default: begin
							resp_load          = 1'b1;
							resp_d.status      = ST_OK;
							resp_d.local_port  = rd_flow.local_port;
							resp_d.remote_port = rd_flow.remote_port;
							resp_d.remote_ip   = rd_flow.remote_ip;
							resp_d.length      = swap16(req_q.byte_count + UDP_HDR_BYTES);
							state_d            = S_IDLE;
						end
					endcase
				end else if (!cmp_vld_q && scan_idx_q >= count_q) begin
					resp_load     = 1'b1;
					resp_d.status = ST_NO_MATCH;
					state_d       = S_IDLE;
				end
			end
			S_MOVE_RD: begin
				mem_raddr = last_idx[AW-1:0];
				state_d   = S_MOVE_WR;
			end
			S_MOVE_WR: begin
				// fill the freed slot with the last entry
				mem_we        = 1'b1;
				mem_waddr     = slot_q;
				mem_wdata     = rd_flow;
				count_dec     = 1'b1;
				resp_load     = 1'b1;
				resp_d.status = ST_OK;
				state_d       = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= '{req_type, peer_ip, peer_port, dest_ip, handle_port, byte_count};
		end
		if (state_q == S_SCAN) begin
			cmp_idx_q <= scan_idx_q[AW-1:0];
		end
		if (state_q == S_SCAN && cmp_vld_q && hit) begin
			slot_q <= cmp_idx_q;
		end
		if (resp_load) begin
			resp_q <= resp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q       <= '0;
			scan_idx_q    <= '0;
			cmp_vld_q     <= 1'b0;
			own_address_q <= '0;
			first_port_q  <= PORT_RESET;
			next_port_q   <= PORT_RESET;
			done_q        <= 1'b0;
		end else begin
			done_q <= resp_load;
			if (count_inc) begin
				count_q <= count_q + 1'b1;
			end else if (count_dec) begin
				count_q <= last_idx;
			end
			if (accept) begin
				scan_idx_q <= '0;
				cmp_vld_q  <= 1'b0;
			end else if (state_q == S_SCAN) begin
				cmp_vld_q <= (scan_idx_q < count_q);
				if (scan_idx_q < count_q) begin
					scan_idx_q <= scan_idx_q + 1'b1;
				end
			end
			if (count_inc) begin
				next_port_q <= (next_port_q == 16'hFFFF) ? first_port_q : next_port_q + 16'd1;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					REG_OWN_ADDRESS: own_address_q <= cfg_data;
					REG_FIRST_PORT: begin
						first_port_q <= cfg_data[15:0];
						next_port_q  <= cfg_data[15:0];
					end
					default: ;
				endcase
			end
		end
	end

	assign done            = done_q;
	assign status          = resp_q.status;
	assign local_port_out  = resp_q.local_port;
	assign remote_port_out = resp_q.remote_port;
	assign remote_ip_out   = resp_q.remote_ip;
	assign length_out      = resp_q.length;

	// every field below status is clear on an error result
	`UFT_ASSERT_IMP(a_count_bound, 1'b1, count_q <= DEPTH_C)
	`UFT_ASSERT_NXT(a_accept_busy, accept, busy)
	`UFT_ASSERT_NXT(a_done_after_busy, busy && resp_load, done && !busy)
	`UFT_ASSERT_IMP(a_err_zero, done && status != ST_OK, resp_q[79:0] == '0)

endmodule

### sim/udp_flow_table_demux_core_tb.sv
`timescale 1ns / 1ps

module udp_flow_table_demux_core_tb;
	import udpft_pkg::*;

	localparam int DEPTH = DEF_TABLE_DEPTH;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  req_type = '0;
	logic [31:0] peer_ip = '0;
	logic [15:0] peer_port = '0;
	logic [31:0] dest_ip = '0;
	logic [15:0] handle_port = '0;
	logic [15:0] byte_count = '0;
	logic        cfg_we = 1'b0;
	logic [0:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic        done;
	logic [1:0]  status;
	logic [15:0] local_port_out;
	logic [15:0] remote_port_out;
	logic [31:0] remote_ip_out;
	logic [15:0] length_out;

	// shadow copy of the socket table and its registers
	flow_t       flow_tab [DEPTH];
	int          flow_cnt = 0;
	logic [15:0] port_ctr = PORT_RESET;
	logic [15:0] base_port = PORT_RESET;
	logic [31:0] host_ip = '0;

	resp_t       replies_due [$];
	int          errors = 0;
	bit          gaps_on = 1'b1;

	udp_flow_table_demux_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.req_type       (req_type),
		.peer_ip        (peer_ip),
		.peer_port      (peer_port),
		.dest_ip        (dest_ip),
		.handle_port    (handle_port),
		.byte_count     (byte_count),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.done           (done),
		.status         (status),
		.local_port_out (local_port_out),
		.remote_port_out(remote_port_out),
		.remote_ip_out  (remote_ip_out),
		.length_out     (length_out)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [15:0] byte_swap(input logic [15:0] v);
		return (v << 8) | (v >> 8);
	endfunction

	function automatic req_t mk(input logic [1:0] kind, input logic [31:0] pip,
			input logic [15:0] pport, input logic [31:0] dip, input logic [15:0] hport,
			input logic [15:0] bc);
		req_t r;
		r.req_type = kind;
		r.peer_ip = pip;
		r.peer_port = pport;
		r.dest_ip = dip;
		r.handle_port = hport;
		r.byte_count = bc;
		return r;
	endfunction

	// receive item whose four-tuple hits table entry idx
	function automatic req_t match_of(input int idx, input logic [15:0] bc);
		return mk(REQ_RECEIVE, flow_tab[idx].remote_ip, flow_tab[idx].remote_port,
			flow_tab[idx].local_ip, flow_tab[idx].local_port, bc);
	endfunction

	// lowest entry with this local port, or -1
	function automatic int first_with_port(input logic [15:0] port);
		int slot;
		slot = -1;
		for (int i = flow_cnt - 1; i >= 0; i--)
			if (flow_tab[i].local_port == port)
				slot = i;
		return slot;
	endfunction

	function automatic resp_t predict_flow_op(input req_t r);
		resp_t o;
		int slot;
		o = '0;
		slot = -1;
		case (r.req_type)
			REQ_CONNECT: begin
				if (flow_cnt >= DEPTH) begin
					o.status = ST_FULL;
				end else begin
					flow_tab[flow_cnt].remote_ip = r.peer_ip;
					flow_tab[flow_cnt].remote_port = byte_swap(r.peer_port);
					flow_tab[flow_cnt].local_ip = host_ip;
					flow_tab[flow_cnt].local_port = byte_swap(port_ctr);
					o.local_port = byte_swap(port_ctr);
					port_ctr = (port_ctr == 16'hFFFF) ? base_port : port_ctr + 16'd1;
					flow_cnt++;
				end
			end
			REQ_DISCONNECT: begin
				slot = first_with_port(r.handle_port);
				if (slot < 0) begin
					o.status = ST_NO_MATCH;
				end else begin
					flow_cnt--;
					flow_tab[slot] = flow_tab[flow_cnt];
				end
			end
			REQ_RECEIVE: begin
				if (r.byte_count < UDP_HDR_BYTES) begin
					o.status = ST_SHORT;
				end else begin
					for (int i = flow_cnt - 1; i >= 0; i--)
						if (flow_tab[i].local_port == r.handle_port &&
								flow_tab[i].remote_port == r.peer_port &&
								flow_tab[i].local_ip == r.dest_ip &&
								flow_tab[i].remote_ip == r.peer_ip)
							slot = i;
					if (slot < 0) begin
						o.status = ST_NO_MATCH;
					end else begin
						o.local_port = flow_tab[slot].local_port;
						o.length = r.byte_count - UDP_HDR_BYTES;
					end
				end
			end
			default: begin
				slot = first_with_port(r.handle_port);
				if (slot < 0) begin
					o.status = ST_NO_MATCH;
				end else begin
					o.local_port = flow_tab[slot].local_port;
					o.remote_port = flow_tab[slot].remote_port;
					o.remote_ip = flow_tab[slot].remote_ip;
					o.length = byte_swap(r.byte_count + UDP_HDR_BYTES);
				end
			end
		endcase
		return o;
	endfunction

	// leave start high on return; the next call or a pause changes it
	task automatic send_item(input req_t r);
		@(negedge clk);
		start = 1'b1;
		req_type = r.req_type;
		peer_ip = r.peer_ip;
		peer_port = r.peer_port;
		dest_ip = r.dest_ip;
		handle_port = r.handle_port;
		byte_count = r.byte_count;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		replies_due.push_back(predict_flow_op(r));
	endtask

	task automatic pause_sender(input int n);
		@(negedge clk);
		start = 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		start = 1'b0;
		while (replies_due.size() != 0 || busy)
			@(negedge clk);
		repeat (24) @(negedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_OWN_ADDRESS: host_ip = val;
			default: begin
				base_port = val[15:0];
				port_ctr = val[15:0];
			end
		endcase
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h got %h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin : result_check
		resp_t want;
		if (arst_n && done) begin
			if (replies_due.size() == 0) begin
				$display("%0t: unexpected result, status %0d port %h", $time, status,
					local_port_out);
				errors++;
			end else begin
				want = replies_due.pop_front();
				check_field("status", 32'(want.status), 32'(status));
				check_field("local_port_out", 32'(want.local_port), 32'(local_port_out));
				check_field("remote_port_out", 32'(want.remote_port),
					32'(remote_port_out));
				check_field("remote_ip_out", want.remote_ip, remote_ip_out);
				check_field("length_out", 32'(want.length), 32'(length_out));
			end
		end
	end

	// reset values: own address zero, counter at 1024
	task automatic test_first_connect();
		send_item(mk(REQ_CONNECT, 32'h0, 16'h0, 32'h0, 16'h0, 16'h0));
	endtask

	task automatic test_short_and_miss();
		send_item(mk(REQ_RECEIVE, 32'h0, 16'h0, 32'h0, 16'h0004, 16'd0));
		send_item(mk(REQ_RECEIVE, 32'h0, 16'h0, 32'h0, 16'h0004, 16'd7));
		send_item(mk(REQ_RECEIVE, 32'h1357_9BDF, 16'h2468, 32'h0, 16'h0004, 16'd8));
		send_item(mk(REQ_DISCONNECT, 32'h0, 16'h0, 32'h0, 16'h0000, 16'h0));
		send_item(mk(REQ_SEND, 32'h0, 16'h0, 32'h0, 16'hFFFF, 16'hFFFF));
	endtask

	task automatic test_request_kinds();
		wait_idle();
		write_reg(REG_OWN_ADDRESS, 32'hFFFF_FFFF);
		send_item(mk(REQ_CONNECT, 32'hFFFF_FFFF, 16'hFFFF, 32'h0, 16'h0, 16'h0));
		send_item(mk(REQ_CONNECT, 32'h0A00_0001, 16'h1234, 32'h0, 16'h0, 16'h0));
		send_item(match_of(1, 16'd8));
		send_item(match_of(2, 16'hFFFF));
		send_item(mk(REQ_SEND, 32'h0, 16'h0, 32'h0, flow_tab[2].local_port, 16'hFFFF));
		send_item(mk(REQ_SEND, 32'h0, 16'h0, 32'h0, flow_tab[0].local_port, 16'h0));
		// removing entry 0 moves the last entry into its slot
		send_item(mk(REQ_DISCONNECT, 32'h0, 16'h0, 32'h0, flow_tab[0].local_port, 16'h0));
		send_item(match_of(0, 16'd100));
	endtask

	task automatic test_port_wrap();
		logic [15:0] dup_port;
		dup_port = byte_swap(16'hFFFE);
		wait_idle();
		write_reg(REG_FIRST_PORT, 32'hDEAD_FFFE);
		repeat (3) send_item(mk(REQ_CONNECT, $urandom, 16'($urandom_range(0, 65535)),
			32'h0, 16'h0, 16'h0));
		// two entries now share a local port; the lower one is hit
		send_item(mk(REQ_SEND, 32'h0, 16'h0, 32'h0, dup_port, 16'hFFF8));
		send_item(mk(REQ_DISCONNECT, 32'h0, 16'h0, 32'h0, dup_port, 16'h0));
		send_item(mk(REQ_SEND, 32'h0, 16'h0, 32'h0, dup_port, 16'h0001));
	endtask

	task automatic test_table_full();
		while (flow_cnt < DEPTH)
			send_item(mk(REQ_CONNECT, $urandom, 16'($urandom_range(0, 65535)), 32'h0,
				16'h0, 16'h0));
		send_item(mk(REQ_CONNECT, 32'h0102_0304, 16'h0506, 32'h0, 16'h0, 16'h0));
		send_item(match_of(DEPTH - 1, 16'd8));
	endtask

	function automatic req_t random_request(input bit grow);
		req_t r;
		int pick;
		int idx;
		r = mk(2'($urandom_range(0, 3)), $urandom, 16'($urandom_range(0, 65535)),
			$urandom, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
		pick = $urandom_range(0, 99);
		idx = (flow_cnt == 0) ? 0 : $urandom_range(0, flow_cnt - 1);
		if (pick < (grow ? 30 : 12)) begin
			r.req_type = REQ_CONNECT;
		end else if (pick < 42) begin
			r.req_type = REQ_DISCONNECT;
			if (flow_cnt != 0)
				r.handle_port = flow_tab[idx].local_port;
		end else if (pick < 70) begin
			if (flow_cnt != 0)
				r = match_of(idx, ($urandom_range(0, 7) == 0) ? 16'd8 :
					16'($urandom_range(8, 65535)));
			// spoil one field of the four-tuple
			if (pick >= 62) begin
				case ($urandom_range(0, 3))
					0: r.peer_ip = r.peer_ip ^ (32'd1 << $urandom_range(0, 31));
					1: r.peer_port = r.peer_port ^ (16'd1 << $urandom_range(0, 15));
					2: r.dest_ip = r.dest_ip ^ (32'd1 << $urandom_range(0, 31));
					default: r.handle_port = r.handle_port ^ (16'd1 << $urandom_range(0, 15));
				endcase
			end
			r.req_type = REQ_RECEIVE;
		end else if (pick < 74) begin
			r.req_type = REQ_RECEIVE;
			r.byte_count = 16'($urandom_range(0, 7));
		end else if (pick < 88) begin
			r.req_type = REQ_SEND;
			if (flow_cnt != 0)
				r.handle_port = flow_tab[idx].local_port;
			if ($urandom_range(0, 3) == 0)
				r.byte_count = 16'hFFFF - 16'($urandom_range(0, 15));
		end
		return r;
	endfunction

	task automatic test_random_traffic();
		logic [31:0] own [6];
		logic [15:0] fp [6];
		own = '{32'hFFFF_FFFF, 32'h0, $urandom, $urandom, $urandom, $urandom};
		fp = '{16'h0000, 16'hFFFF, 16'hFFF0, 16'($urandom), 16'($urandom), PORT_RESET};
		for (int ph = 0; ph < 6; ph++) begin
			wait_idle();
			write_reg(REG_OWN_ADDRESS, own[ph]);
			write_reg(REG_FIRST_PORT, {16'($urandom), fp[ph]});
			gaps_on = (ph != 5);
			for (int n = 0; n < 210; n++) begin
				if (gaps_on && (n % 60) < 40 && $urandom_range(0, 3) == 0)
					pause_sender($urandom_range(1, 11));
				send_item(random_request(((n / 35) % 2) == 0));
			end
		end
	endtask

	initial begin
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		test_first_connect();
		test_short_and_miss();
		test_request_kinds();
		test_port_wrap();
		test_table_full();
		test_random_traffic();
		wait_idle();
		if (errors == 0)
			$display("udp_flow_table_demux_core_tb OK");
		else
			$display("udp_flow_table_demux_core_tb NOT OK");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("udp_flow_table_demux_core_tb NOT OK");
		$finish;
	end

endmodule

### sim.f
+incdir+rtl
rtl/udpft_pkg.sv
rtl/udpft_table.sv
rtl/udp_flow_table_demux_core.sv
sim/udp_flow_table_demux_core_tb.sv
